### sv/pts_pkg.sv
// shared constants, types and command codes of the periodic task scheduler
package pts_pkg;

    localparam int NUM_TASKS_DEF = 8;
    localparam int MAX_RESULTS   = 8;

    localparam int COUNT_W  = 4;
    localparam int INDEX_W  = 3;
    localparam int PERIOD_W = 16;
    localparam int TIME_W   = 32;
    localparam int DUE_W    = 23;

    // floor(x / 1000) = (x * ceil(2^38 / 1000)) >> 38 for every 32-bit x
    localparam int MS_DIVISOR  = 1000;
    localparam int RECIP_SHIFT = 38;
    localparam int RECIP_W     = 29;
    localparam int PROD_W      = TIME_W + RECIP_W;
    localparam logic [RECIP_W-1:0] MS_RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MS_DIVISOR) - 64'd1) / 64'(MS_DIVISOR));

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_LOAD   = 2'd1,
        CMD_SET_EN = 2'd2,
        CMD_QUERY  = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [DUE_W-1:0]    due;
    } entry_t;

endpackage

### sv/pts_ms_conv.sv
// microsecond to millisecond conversion by registered reciprocal multiply
module pts_ms_conv
(
    input  logic                       clk,
    input  logic                       load,
    input  logic                       calc,
    input  logic [pts_pkg::TIME_W-1:0] time_us,
    output logic [pts_pkg::DUE_W-1:0]  now_ms
);

    logic [pts_pkg::TIME_W-1:0] time_reg;
    logic [pts_pkg::DUE_W-1:0]  now_reg;
    logic [pts_pkg::PROD_W-1:0] prod;

    assign prod   = pts_pkg::PROD_W'(time_reg) * pts_pkg::PROD_W'(pts_pkg::MS_RECIP);
    assign now_ms = now_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            time_reg <= time_us;
        end
        if (calc)
        begin
            now_reg <= prod[pts_pkg::RECIP_SHIFT +: pts_pkg::DUE_W];
        end
    end

endmodule

### sv/periodic_task_scheduler.sv
// periodic task scheduler top level
// Keeps up to NUM_TASKS periodic tasks (period, enable, next-due time in ms) in a
// single-port task memory with registered reads plus per-task enable and
// due-valid flip-flops. A tick converts its microsecond time to ms, then walks
// the tasks in use one by one (memory read, then check and write-back), firing
// every enabled task that is due, up to MAX_RESULTS per tick, and emitting one
// transaction per fired task, or one empty transaction. Load, set-enable and
// query emit one transaction each.
// One command is worked on at a time; the next is taken as soon as its final
// transaction is pushed, even while that result still waits in the output register,
// and output back-pressure only stalls the walk when a second result has to leave.
module periodic_task_scheduler
#(
    parameter int NUM_TASKS = pts_pkg::NUM_TASKS_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,

    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [pts_pkg::COUNT_W-1:0]  cfg_data,

    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   cmd,
    input  logic [pts_pkg::INDEX_W-1:0]  task_index,
    input  logic [pts_pkg::PERIOD_W-1:0] period_ms,
    input  logic                         enable_value,
    input  logic [pts_pkg::TIME_W-1:0]   time_us,

    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         fired,
    output logic [pts_pkg::INDEX_W-1:0]  fired_index,
    output logic                         found,
    output logic                         enable_out,
    output logic [pts_pkg::PERIOD_W-1:0] period_out,
    output logic                         last
);

    localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_RD,
        S_CHK,
        S_END,
        S_RESP
    } state_t;

    state_t                         state_reg;
    logic [pts_pkg::COUNT_W-1:0]    count_reg;
    pts_pkg::cmd_t                  cmd_reg;
    logic [pts_pkg::INDEX_W-1:0]    idx_reg;
    logic                           found_reg;
    logic [NUM_TASKS-1:0]           en_reg;
    logic [NUM_TASKS-1:0]           dv_reg;
    logic [pts_pkg::COUNT_W-1:0]    i_reg;
    logic [pts_pkg::COUNT_W-1:0]    n_reg;
    logic                           hold_vld_reg;
    logic [pts_pkg::INDEX_W-1:0]    hold_idx_reg;

    logic                           out_valid_reg;
    logic                           fired_reg;
    logic [pts_pkg::INDEX_W-1:0]    fired_index_reg;
    logic                           found_out_reg;
    logic                           enable_out_reg;
    logic [pts_pkg::PERIOD_W-1:0]   period_out_reg;
    logic                           last_reg;

    pts_pkg::entry_t                mem [NUM_TASKS];
    pts_pkg::entry_t                rd_reg;

    pts_pkg::cmd_t                  cmd_in;
    logic                           in_acc;
    logic [pts_pkg::COUNT_W-1:0]    in_use;
    logic                           idx_in_table;
    logic                           idx_in_use;
    logic [AW-1:0]                  idx_addr;
    logic [AW-1:0]                  walk_addr;
    logic [AW-1:0]                  resp_addr;
    logic [pts_pkg::DUE_W-1:0]      now_ms;
    logic [pts_pkg::DUE_W-1:0]      due_cur;
    logic                           fire;
    logic                           out_free;
    logic                           chk_go;
    logic                           walk_done;

    logic                           mem_we;
    logic                           mem_re;
    logic [AW-1:0]                  mem_waddr;
    logic [AW-1:0]                  mem_raddr;
    pts_pkg::entry_t                mem_wdata;

    logic                           res_push;
    logic                           res_fired;
    logic [pts_pkg::INDEX_W-1:0]    res_idx;
    logic                           res_found;
    logic                           res_en;
    logic [pts_pkg::PERIOD_W-1:0]   res_period;
    logic                           res_last;

    assign cfg_ready   = 1'b1;
    assign in_ready    = (state_reg == S_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign cmd_in      = pts_pkg::cmd_t'(cmd);

    assign out_valid   = out_valid_reg;
    assign fired       = fired_reg;
    assign fired_index = fired_index_reg;
    assign found       = found_out_reg;
    assign enable_out  = enable_out_reg;
    assign period_out  = period_out_reg;
    assign last        = last_reg;

    // tasks in use is min(task_count, NUM_TASKS)
    assign in_use = (int'(count_reg) < NUM_TASKS) ? count_reg
                                                  : pts_pkg::COUNT_W'(NUM_TASKS);

    assign idx_in_table = int'(task_index) < NUM_TASKS;
    assign idx_in_use   = {1'b0, task_index} < in_use;
    assign idx_addr     = AW'(task_index);
    assign walk_addr    = AW'(i_reg);
    assign resp_addr    = AW'(idx_reg);

    assign due_cur   = dv_reg[walk_addr] ? rd_reg.due : '0;
    assign fire      = en_reg[walk_addr] && (now_ms >= due_cur);
    assign out_free  = !out_valid_reg || out_ready;
    assign chk_go    = (state_reg == S_CHK) && !(fire && hold_vld_reg && !out_free);
    assign walk_done = ((i_reg + 4'd1) == in_use) ||
                       (fire && ((n_reg + 4'd1) == pts_pkg::COUNT_W'(pts_pkg::MAX_RESULTS)));

    pts_ms_conv u_conv
    (
        .clk     (clk),
        .load    (in_acc && (cmd_in == pts_pkg::CMD_TICK)),
        .calc    (state_reg == S_CONV),
        .time_us (time_us),
        .now_ms  (now_ms)
    );

    // task memory: load writes from the input, the walk writes back the new due time
    always_comb
    begin
        mem_we    = (in_acc && (cmd_in == pts_pkg::CMD_LOAD) && idx_in_table) ||
                    (chk_go && fire);
        mem_re    = (in_acc && (cmd_in == pts_pkg::CMD_QUERY) && idx_in_table) ||
                    (state_reg == S_RD);
        mem_waddr = (state_reg == S_IDLE) ? idx_addr : walk_addr;
        mem_raddr = (state_reg == S_IDLE) ? idx_addr : walk_addr;
        if (state_reg == S_IDLE)
        begin
            mem_wdata.period = period_ms;
            mem_wdata.due    = '0;
        end
        else
        begin
            mem_wdata.period = rd_reg.period;
            mem_wdata.due    = now_ms + pts_pkg::DUE_W'(rd_reg.period);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_reg <= mem[mem_raddr];
        end
    end

    // result transaction to the output register
    always_comb
    begin
        res_push   = 1'b0;
        res_fired  = 1'b0;
        res_idx    = '0;
        res_found  = 1'b0;
        res_en     = 1'b0;
        res_period = '0;
        res_last   = 1'b0;
        unique case (state_reg)
            S_CHK:
            begin
                if (chk_go && fire && hold_vld_reg)
                begin
                    res_push  = 1'b1;
                    res_fired = 1'b1;
                    res_idx   = hold_idx_reg;
                end
            end
            S_END:
            begin
                if (out_free)
                begin
                    res_push  = 1'b1;
                    res_fired = hold_vld_reg;
                    res_idx   = hold_vld_reg ? hold_idx_reg : '0;
                    res_last  = 1'b1;
                end
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    res_push = 1'b1;
                    res_last = 1'b1;
                    if (cmd_reg == pts_pkg::CMD_SET_EN)
                    begin
                        res_found = found_reg;
                    end
                    if (cmd_reg == pts_pkg::CMD_QUERY)
                    begin
                        res_idx    = idx_reg;
                        res_found  = found_reg;
                        res_en     = found_reg ? en_reg[resp_addr] : 1'b0;
                        res_period = found_reg ? rd_reg.period : '0;
                    end
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            count_reg       <= '0;
            cmd_reg         <= pts_pkg::CMD_TICK;
            idx_reg         <= '0;
            found_reg       <= 1'b0;
            en_reg          <= '0;
            dv_reg          <= '0;
            i_reg           <= '0;
            n_reg           <= '0;
            hold_vld_reg    <= 1'b0;
            hold_idx_reg    <= '0;
            out_valid_reg   <= 1'b0;
            fired_reg       <= 1'b0;
            fired_index_reg <= '0;
            found_out_reg   <= 1'b0;
            enable_out_reg  <= 1'b0;
            period_out_reg  <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end

            if (res_push)
            begin
                out_valid_reg   <= 1'b1;
                fired_reg       <= res_fired;
                fired_index_reg <= res_idx;
                found_out_reg   <= res_found;
                enable_out_reg  <= res_en;
                period_out_reg  <= res_period;
                last_reg        <= res_last;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        cmd_reg   <= cmd_in;
                        idx_reg   <= task_index;
                        found_reg <= idx_in_use;
                        unique case (cmd_in)
                            pts_pkg::CMD_TICK:
                            begin
                                state_reg <= S_CONV;
                            end
                            pts_pkg::CMD_LOAD:
                            begin
                                if (idx_in_table)
                                begin
                                    en_reg[idx_addr] <= enable_value;
                                    dv_reg[idx_addr] <= 1'b1;
                                end
                                state_reg <= S_RESP;
                            end
                            pts_pkg::CMD_SET_EN:
                            begin
                                if (idx_in_use)
                                begin
                                    en_reg[idx_addr] <= enable_value;
                                end
                                state_reg <= S_RESP;
                            end
                            pts_pkg::CMD_QUERY:
                            begin
                                state_reg <= S_RESP;
                            end
                            default:
                            begin
                                state_reg <= S_RESP;
                            end
                        endcase
                    end
                end
                S_CONV:
                begin
                    i_reg        <= '0;
                    n_reg        <= '0;
                    hold_vld_reg <= 1'b0;
                    state_reg    <= (in_use == '0) ? S_END : S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (chk_go)
                    begin
                        if (fire)
                        begin
                            dv_reg[walk_addr] <= 1'b1;
                            hold_idx_reg      <= i_reg[pts_pkg::INDEX_W-1:0];
                            hold_vld_reg      <= 1'b1;
                            n_reg             <= n_reg + 4'd1;
                        end
                        if (walk_done)
                        begin
                            state_reg <= S_END;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 4'd1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_END:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_RESP:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // one command in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !in_ready)
        else $error("input taken while a command is in flight");

    // a tick never reports more than the result limit
    a_fire_limit: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= pts_pkg::COUNT_W'(pts_pkg::MAX_RESULTS))
        else $error("fire count beyond result limit");

    // the walk only reads tasks in use
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |-> (i_reg < in_use))
        else $error("walk index beyond tasks in use");

    // the final transaction of a command returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && res_last) |=> (state_reg == S_IDLE))
        else $error("final transaction not followed by idle");

    // a non-final transaction only comes from a tick that fired a task
    a_mid_fired: assert property (@(posedge clk) disable iff (!rst_n)
        (res_push && !res_last) |-> (res_fired && fire && hold_vld_reg))
        else $error("non-final transaction without a fired task");

endmodule
